[rtl/ftc_pkg.sv]
package ftc_pkg;

  localparam int FRAME_COUNT_DEF = 64;
  localparam int OWNER_BITS_DEF  = 16;
  localparam int PAGE_BITS_DEF   = 16;
  localparam int FIDX_W          = 6;
  localparam int COUNT_W         = 7;

  typedef enum logic [2:0] {
    MODE_INSERT    = 3'd0,
    MODE_LOOKUP    = 3'd1,
    MODE_MARK_USED = 3'd2,
    MODE_MARK_ALL  = 3'd3,
    MODE_CLOCK     = 3'd4,
    MODE_ENHANCED  = 3'd5,
    MODE_REPLACE   = 3'd6,
    MODE_REMOVE    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_NEXT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic next;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic hit;
    logic next_found;
    logic out_free;
  } sts_t;

endpackage

[rtl/ftc_if.sv]
interface ftc_in_if #(
  parameter int OWNER_BITS = ftc_pkg::OWNER_BITS_DEF,
  parameter int PAGE_BITS  = ftc_pkg::PAGE_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [2:0]                mode;
  logic [OWNER_BITS-1:0]     owner_id;
  logic [PAGE_BITS-1:0]      page_number;
  logic [ftc_pkg::FIDX_W-1:0] frame_index;
  logic [ftc_pkg::FIDX_W-1:0] clock_hand;
  logic                      init_used;
  logic                      init_modified;

  modport source (output valid, mode, owner_id, page_number, frame_index, clock_hand,
                  init_used, init_modified, input ready);
  modport sink (input valid, mode, owner_id, page_number, frame_index, clock_hand,
                init_used, init_modified, output ready);
endinterface

interface ftc_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ftc_pkg::FIDX_W-1:0]  result_frame;
  logic [ftc_pkg::FIDX_W-1:0]  next_hand;
  logic [ftc_pkg::COUNT_W-1:0] occupied_count;

  modport source (output valid, status, result_frame, next_hand, occupied_count,
                  input ready);
  modport sink (input valid, status, result_frame, next_hand, occupied_count,
                output ready);
endinterface

[rtl/ftc_ctrl.sv]
module ftc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ftc_pkg::sts_t sts_i,
  output ftc_pkg::cmd_t cmd_o
);
  import ftc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.fin) state_d = sts_i.hit ? S_NEXT : S_RESP;
      end
      S_NEXT: begin
        if (sts_i.next_found) state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan  = (state_q == S_SCAN);
    cmd_o.next  = (state_q == S_NEXT);
    cmd_o.resp  = (state_q == S_RESP) && sts_i.out_free;
  end

  // a hit that ends the frame scan starts the hunt for the next occupied frame
  a_next_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.fin && sts_i.hit) |=> state_q == S_NEXT)
    else $error("hit did not start next-occupied scan");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_o.load)
    else $error("request taken while busy");
  a_resp_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.resp |=> state_q == S_IDLE)
    else $error("response did not return to idle");

endmodule

[rtl/ftc_dp.sv]
module ftc_dp #(
  parameter int FRAME_COUNT = ftc_pkg::FRAME_COUNT_DEF,
  parameter int OWNER_BITS  = ftc_pkg::OWNER_BITS_DEF,
  parameter int PAGE_BITS   = ftc_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ftc_pkg::cmd_t                cmd_i,
  output ftc_pkg::sts_t                sts_o,
  input  logic [2:0]                   mode_i,
  input  logic [OWNER_BITS-1:0]        owner_id_i,
  input  logic [PAGE_BITS-1:0]         page_number_i,
  input  logic [ftc_pkg::FIDX_W-1:0]   frame_index_i,
  input  logic [ftc_pkg::FIDX_W-1:0]   clock_hand_i,
  input  logic                         init_used_i,
  input  logic                         init_modified_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [ftc_pkg::FIDX_W-1:0]   result_frame_o,
  output logic [ftc_pkg::FIDX_W-1:0]   next_hand_o,
  output logic [ftc_pkg::COUNT_W-1:0]  occupied_count_o
);
  import ftc_pkg::*;

  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW = $clog2(FRAME_COUNT + 1);
  localparam logic [FW-1:0] LAST = FW'(FRAME_COUNT - 1);

  logic [OWNER_BITS-1:0] owner_mem [FRAME_COUNT];
  logic [PAGE_BITS-1:0]  page_mem  [FRAME_COUNT];
  logic [OWNER_BITS-1:0] own_rd_q;
  logic [PAGE_BITS-1:0]  page_rd_q;

  mode_e                 mode_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [FW-1:0]         fsel_q;
  logic                  fok_q;
  logic                  iu_q, im_q;
  logic [FW-1:0]         start_q;

  logic [FW-1:0]          ptr_q, ptr_d, k_q, k_d, ptr_wrap, frame;
  logic [1:0]             pass_q, pass_d;
  logic [FRAME_COUNT-1:0] valid_q, valid_d, used_q, used_d, mod_q, mod_d;
  logic [CW-1:0]          count_q, count_d;
  logic [FW-1:0]          res_frame_q, res_frame_d, next_q, next_d;
  status_e                res_st_q, res_st_d;
  logic                   own_we, page_we;
  logic [FW-1:0]          wr_addr;
  logic                   hit, fin, pass_end, last_pass, cur_v, cur_u, cur_m;
  logic                   next_found;
  logic [FW-1:0]          hand_start;
  logic                   out_valid_q;
  status_e                out_st_q;
  logic [FW-1:0]          out_frame_q, out_next_q;
  logic [CW-1:0]          out_count_q;

  assign hand_start = (int'(clock_hand_i) < FRAME_COUNT) ? FW'(clock_hand_i) : '0;
  assign ptr_wrap   = (frame == LAST) ? '0 : frame + 1'b1;
  assign cur_v      = valid_q[ptr_q];
  assign cur_u      = used_q[ptr_q];
  assign cur_m      = mod_q[ptr_q];
  assign pass_end   = (k_q == LAST);
  assign last_pass  = (mode_q == MODE_CLOCK) ? (pass_q == 2'd1) : (pass_q == 2'd3);

  always_comb begin
    ptr_d       = ptr_q;
    k_d         = k_q;
    pass_d      = pass_q;
    valid_d     = valid_q;
    used_d      = used_q;
    mod_d       = mod_q;
    count_d     = count_q;
    res_frame_d = res_frame_q;
    res_st_d    = res_st_q;
    next_d      = next_q;
    own_we      = 1'b0;
    page_we     = 1'b0;
    wr_addr     = ptr_q;
    hit         = 1'b0;
    fin         = 1'b0;
    frame       = ptr_q;
    next_found  = 1'b0;
    if (cmd_i.load) begin
      ptr_d  = (mode_e'(mode_i) == MODE_CLOCK || mode_e'(mode_i) == MODE_ENHANCED)
               ? hand_start : '0;
      k_d    = '0;
      pass_d = '0;
    end else if (cmd_i.scan) begin
      unique case (mode_q)
        MODE_INSERT: begin
          hit = !cur_v;
          fin = hit || pass_end;
          res_st_d = hit ? ST_OK : ST_FULL;
          if (hit) begin
            valid_d[ptr_q] = 1'b1;
            used_d[ptr_q]  = iu_q;
            mod_d[ptr_q]   = im_q;
            count_d        = count_q + 1'b1;
            own_we         = 1'b1;
            page_we        = 1'b1;
          end
        end
        MODE_LOOKUP: begin
          hit = cur_v && own_rd_q == owner_q && page_rd_q == page_q;
          fin = hit || pass_end;
          res_st_d = hit ? ST_OK : ST_MISS;
        end
        MODE_REMOVE: begin
          fin = pass_end;
          res_st_d = ST_OK;
          if (cur_v && own_rd_q == owner_q) begin
            valid_d[ptr_q] = 1'b0;
            used_d[ptr_q]  = 1'b0;
            mod_d[ptr_q]   = 1'b0;
            count_d        = count_q - 1'b1;
          end
        end
        MODE_CLOCK: begin
          hit = cur_v && !cur_u;
          if (cur_v) used_d[ptr_q] = 1'b0;
          fin = hit || (pass_end && last_pass);
          res_st_d = hit ? ST_OK : ST_MISS;
        end
        MODE_ENHANCED: begin
          if (!pass_q[0]) begin
            hit = cur_v && !cur_u && !cur_m;
          end else begin
            hit = cur_v && !cur_u && cur_m;
            if (cur_v && !hit) used_d[ptr_q] = 1'b0;
          end
          fin = hit || (pass_end && last_pass);
          res_st_d = hit ? ST_OK : ST_MISS;
        end
        MODE_MARK_USED: begin
          frame = fsel_q;
          hit = fok_q && valid_q[fsel_q];
          fin = 1'b1;
          res_st_d = hit ? ST_OK : ST_MISS;
          if (hit) used_d[fsel_q] = 1'b1;
        end
        MODE_REPLACE: begin
          frame = fsel_q;
          hit = fok_q && valid_q[fsel_q];
          fin = 1'b1;
          res_st_d = hit ? ST_OK : ST_MISS;
          wr_addr = fsel_q;
          if (hit) begin
            page_we        = 1'b1;
            used_d[fsel_q] = 1'b1;
            mod_d[fsel_q]  = 1'b0;
          end
        end
        MODE_MARK_ALL: begin
          frame = fsel_q;
          fin = 1'b1;
          res_st_d = ST_OK;
          mod_d = mod_q | valid_q;
        end
        default: ;
      endcase
      if (fin) begin
        res_frame_d = hit ? frame : '0;
        next_d      = '0;
        ptr_d       = ptr_wrap;
      end else if (pass_end) begin
        // another pass from the hand
        ptr_d  = start_q;
        k_d    = '0;
        pass_d = pass_q + 1'b1;
      end else begin
        ptr_d = ptr_wrap;
        k_d   = k_q + 1'b1;
      end
    end else if (cmd_i.next) begin
      // hunt for the next occupied frame, one per cycle
      if (valid_q[ptr_q]) begin
        next_found = 1'b1;
        next_d = ptr_q;
      end else begin
        ptr_d = ptr_wrap;
      end
    end
  end

  assign sts_o.fin        = fin;
  assign sts_o.hit        = hit;
  assign sts_o.next_found = next_found;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (own_we) owner_mem[wr_addr] <= owner_q;
    if (page_we) page_mem[wr_addr] <= page_q;
    own_rd_q  <= owner_mem[ptr_d];
    page_rd_q <= page_mem[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      owner_q <= owner_id_i;
      page_q  <= page_number_i;
      fsel_q  <= FW'(frame_index_i);
      fok_q   <= int'(frame_index_i) < FRAME_COUNT;
      iu_q    <= init_used_i;
      im_q    <= init_modified_i;
      start_q <= hand_start;
    end
    ptr_q       <= ptr_d;
    k_q         <= k_d;
    pass_q      <= pass_d;
    res_frame_q <= res_frame_d;
    res_st_q    <= res_st_d;
    next_q      <= next_d;
    if (cmd_i.resp) begin
      out_st_q    <= res_st_q;
      out_frame_q <= res_frame_q;
      out_next_q  <= next_q;
      out_count_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      used_q      <= '0;
      mod_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
      mod_q   <= mod_d;
      count_q <= count_d;
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign result_frame_o   = FIDX_W'(out_frame_q);
  assign next_hand_o      = FIDX_W'(out_next_q);
  assign occupied_count_o = COUNT_W'(out_count_q);

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("occupied count out of step with valid bits");
  a_used_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q & ~valid_q) == '0)
    else $error("used bit on a free frame");
  a_mod_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_q & ~valid_q) == '0)
    else $error("modified bit on a free frame");
  a_next_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.next_found |=> valid_q[next_q])
    else $error("next hand points at a free frame");

endmodule

[rtl/frame_table_clock_replacement.sv]
// frame table with clock and enhanced-clock victim search
//
// in_i carries one request per handshake (valid && ready): mode, owner,
// page, frame index, clock hand and the initial used/modified bits.
// out_o returns exactly one response per request: status, result frame,
// next occupied frame after it and the occupied count.
//
// requests are handled one at a time; ready is high only while idle, so
// a new request can be taken at the earliest in the cycle after the
// previous response is loaded. every scan steps one frame per cycle,
// paced by the single read port of the owner/page memories. mark used
// and replace touch one frame, mark all modified all occupied frames;
// insert and lookup stop at the first hit or after one pass from frame
// 0, remove owner makes one full pass, clock victim up to two passes
// from the hand, enhanced up to four; a hit then hunts for the next
// occupied frame. the response sits in an output register; a stalled
// receiver holds it and the block waits with the next response until it
// is taken. reset clears all valid, used and modified bits and the count;
// owner and page storage is not cleared, and no clearing pass is needed.
module frame_table_clock_replacement #(
  parameter int FRAME_COUNT = ftc_pkg::FRAME_COUNT_DEF,
  parameter int OWNER_BITS  = ftc_pkg::OWNER_BITS_DEF,
  parameter int PAGE_BITS   = ftc_pkg::PAGE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ftc_in_if.sink    in_i,
  ftc_out_if.source out_o
);
  import ftc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  ftc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  ftc_dp #(
    .FRAME_COUNT (FRAME_COUNT),
    .OWNER_BITS  (OWNER_BITS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (in_i.mode),
    .owner_id_i       (in_i.owner_id),
    .page_number_i    (in_i.page_number),
    .frame_index_i    (in_i.frame_index),
    .clock_hand_i     (in_i.clock_hand),
    .init_used_i      (in_i.init_used),
    .init_modified_i  (in_i.init_modified),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .status_o         (out_o.status),
    .result_frame_o   (out_o.result_frame),
    .next_hand_o      (out_o.next_hand),
    .occupied_count_o (out_o.occupied_count)
  );

endmodule
